### hw/rtl/ifr_pkg.sv
// Shared types, codes and helpers of the information frame receiver.
`default_nettype none

package ifr_pkg;

    // Width of the internal payload byte counter.
    localparam int LEN_WIDTH = 16;
    localparam int FRAME_LEN_W = 16;
    localparam int LEN_EXT_W = (LEN_WIDTH > FRAME_LEN_W) ? LEN_WIDTH : FRAME_LEN_W;

    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_BYTE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STUFF_MASK       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENDER_ADDRESS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECEIVER_ADDRESS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_CTRL_SEQ0   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_CTRL_SEQ1   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_CTRL        = 3'd7;

    // Result kinds.
    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_ACCEPT    = 3'd1;
    localparam logic [2:0] KIND_REJECT    = 3'd2;
    localparam logic [2:0] KIND_DUPLICATE = 3'd3;
    localparam logic [2:0] KIND_DISC      = 3'd4;

    // Supervision reply kinds.
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_RR   = 2'd1;
    localparam logic [1:0] REPLY_REJ  = 2'd2;
    localparam logic [1:0] REPLY_DISC = 2'd3;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] stuff_mask;
        logic [7:0] sender_address;
        logic [7:0] receiver_address;
        logic [7:0] info_ctrl_seq0;
        logic [7:0] info_ctrl_seq1;
        logic [7:0] disc_ctrl;
    } cfg_t;

    typedef struct packed {
        logic [2:0]             kind;
        logic [7:0]             data_byte;
        logic [1:0]             reply_kind;
        logic                   reply_seq;
        logic [7:0]             reply_address;
        logic [FRAME_LEN_W-1:0] frame_length;
    } result_t;

    // Clamp the byte counter to the width of the reported frame length.
    function automatic logic [FRAME_LEN_W-1:0] sat_len(input logic [LEN_WIDTH-1:0] count);
        logic [LEN_EXT_W-1:0] ext;
        logic [LEN_EXT_W-1:0] max_len;
        logic [FRAME_LEN_W-1:0] ones;
        ext = LEN_EXT_W'(count);
        ones = '1;
        max_len = LEN_EXT_W'(ones);
        if (ext > max_len)
        begin
            return ones;
        end
        return ext[FRAME_LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ifr_cfg_regs.sv
// Configuration register bank of the information frame receiver.
`default_nettype none

module ifr_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ifr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    output ifr_pkg::cfg_t                      cfg
);

    ifr_pkg::cfg_t cfg_reg;
    ifr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                ifr_pkg::CFG_FLAG_BYTE:        cfg_next.flag_byte        = cfg_data;
                ifr_pkg::CFG_ESCAPE_BYTE:      cfg_next.escape_byte      = cfg_data;
                ifr_pkg::CFG_STUFF_MASK:       cfg_next.stuff_mask       = cfg_data;
                ifr_pkg::CFG_SENDER_ADDRESS:   cfg_next.sender_address   = cfg_data;
                ifr_pkg::CFG_RECEIVER_ADDRESS: cfg_next.receiver_address = cfg_data;
                ifr_pkg::CFG_INFO_CTRL_SEQ0:   cfg_next.info_ctrl_seq0   = cfg_data;
                ifr_pkg::CFG_INFO_CTRL_SEQ1:   cfg_next.info_ctrl_seq1   = cfg_data;
                ifr_pkg::CFG_DISC_CTRL:        cfg_next.disc_ctrl        = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte        <= 8'h7E;
            cfg_reg.escape_byte      <= 8'h7D;
            cfg_reg.stuff_mask       <= 8'h20;
            cfg_reg.sender_address   <= 8'h03;
            cfg_reg.receiver_address <= 8'h01;
            cfg_reg.info_ctrl_seq0   <= 8'h00;
            cfg_reg.info_ctrl_seq1   <= 8'h40;
            cfg_reg.disc_ctrl        <= 8'h0B;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hw/rtl/ifr_decoder.sv
// Input register, frame state machine and destuffing logic of the receiver.
`default_nettype none

module ifr_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ifr_pkg::cfg_t cfg,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance,
    output logic            step,
    output logic            res_valid,
    output ifr_pkg::result_t res
);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_FLAG = 3'd1;
    localparam logic [2:0] PH_ADDR = 3'd2;
    localparam logic [2:0] PH_CTRL = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_ESC  = 3'd5;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic       expected_seq_reg;
    logic       expected_seq_next;
    logic [7:0] held_control_reg;
    logic [7:0] held_control_next;
    logic [7:0] held_byte_reg;
    logic [7:0] held_byte_next;
    logic       held_valid_reg;
    logic       held_valid_next;
    logic [7:0] running_check_reg;
    logic [7:0] running_check_next;
    logic [ifr_pkg::LEN_WIDTH-1:0] byte_count_reg;
    logic [ifr_pkg::LEN_WIDTH-1:0] byte_count_next;

    logic       in_fire;
    logic [7:0] b;
    logic [7:0] exp_ctrl;
    logic [7:0] dup_ctrl;
    logic       take_en;
    logic [7:0] take_byte;

    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;
    assign step     = s1_valid_reg && advance;
    assign b        = s1_byte_reg;
    assign exp_ctrl = expected_seq_reg ? cfg.info_ctrl_seq1 : cfg.info_ctrl_seq0;
    assign dup_ctrl = expected_seq_reg ? cfg.info_ctrl_seq0 : cfg.info_ctrl_seq1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        expected_seq_next  = expected_seq_reg;
        held_control_next  = held_control_reg;
        held_byte_next     = held_byte_reg;
        held_valid_next    = held_valid_reg;
        running_check_next = running_check_reg;
        byte_count_next    = byte_count_reg;
        res_valid          = 1'b0;
        res                = '0;
        take_en            = 1'b0;
        take_byte          = b;

        if (step)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (b == cfg.flag_byte)
                    begin
                        phase_next = PH_FLAG;
                    end
                end
                PH_FLAG:
                begin
                    if (b == cfg.sender_address)
                    begin
                        phase_next = PH_ADDR;
                    end
                    else if (b != cfg.flag_byte)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_ADDR:
                begin
                    // Expected control wins over duplicate, then disconnect, then flag.
                    if (b == exp_ctrl)
                    begin
                        held_control_next = b;
                        phase_next        = PH_CTRL;
                    end
                    else if (b == dup_ctrl)
                    begin
                        phase_next        = PH_HUNT;
                        res_valid         = 1'b1;
                        res.kind          = ifr_pkg::KIND_DUPLICATE;
                        res.reply_kind    = ifr_pkg::REPLY_RR;
                        res.reply_seq     = !expected_seq_reg;
                        res.reply_address = cfg.sender_address;
                    end
                    else if (b == cfg.disc_ctrl)
                    begin
                        phase_next        = PH_HUNT;
                        res_valid         = 1'b1;
                        res.kind          = ifr_pkg::KIND_DISC;
                        res.reply_kind    = ifr_pkg::REPLY_DISC;
                        res.reply_address = cfg.sender_address;
                    end
                    else if (b == cfg.flag_byte)
                    begin
                        phase_next = PH_FLAG;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_CTRL:
                begin
                    if (b == (held_control_reg ^ cfg.sender_address))
                    begin
                        phase_next         = PH_DATA;
                        held_valid_next    = 1'b0;
                        held_byte_next     = '0;
                        running_check_next = '0;
                        byte_count_next    = '0;
                    end
                    else if (b == cfg.flag_byte)
                    begin
                        phase_next = PH_FLAG;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    if (b == cfg.escape_byte)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if (b == cfg.flag_byte)
                    begin
                        // Closing flag: the held byte is the check of the payload.
                        phase_next        = PH_HUNT;
                        held_valid_next   = 1'b0;
                        res_valid         = 1'b1;
                        res.reply_seq     = expected_seq_reg;
                        res.reply_address = cfg.receiver_address;
                        if (held_valid_reg && (held_byte_reg == running_check_reg))
                        begin
                            res.kind          = ifr_pkg::KIND_ACCEPT;
                            res.reply_kind    = ifr_pkg::REPLY_RR;
                            res.frame_length  = ifr_pkg::sat_len(byte_count_reg);
                            expected_seq_next = !expected_seq_reg;
                        end
                        else
                        begin
                            res.kind       = ifr_pkg::KIND_REJECT;
                            res.reply_kind = ifr_pkg::REPLY_REJ;
                            if (held_valid_reg)
                            begin
                                res.frame_length = ifr_pkg::sat_len(byte_count_reg);
                            end
                        end
                    end
                    else
                    begin
                        take_en = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_DATA;
                    take_en    = 1'b1;
                    take_byte  = b ^ cfg.stuff_mask;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // A new payload byte pushes out the one held before it.
        if (take_en)
        begin
            if (held_valid_reg)
            begin
                res_valid          = 1'b1;
                res.kind           = ifr_pkg::KIND_PAYLOAD;
                res.data_byte      = held_byte_reg;
                running_check_next = running_check_reg ^ held_byte_reg;
                if (byte_count_reg != '1)
                begin
                    byte_count_next = byte_count_reg + 1'b1;
                end
            end
            held_byte_next  = take_byte;
            held_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            phase_reg         <= PH_HUNT;
            expected_seq_reg  <= 1'b0;
            held_control_reg  <= '0;
            held_byte_reg     <= '0;
            held_valid_reg    <= 1'b0;
            running_check_reg <= '0;
            byte_count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            phase_reg         <= phase_next;
            expected_seq_reg  <= expected_seq_next;
            held_control_reg  <= held_control_next;
            held_byte_reg     <= held_byte_next;
            held_valid_reg    <= held_valid_next;
            running_check_reg <= running_check_next;
            byte_count_reg    <= byte_count_next;
        end
    end

    // The expected sequence only moves when a frame is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (expected_seq_reg != $past(expected_seq_reg)) |->
        $past(step && res_valid && (res.kind == ifr_pkg::KIND_ACCEPT)))
        else $error("expected sequence changed without an accepted frame");

    // A held payload byte exists only inside a frame's data field.
    assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> ((phase_reg == PH_DATA) || (phase_reg == PH_ESC)))
        else $error("held byte valid outside the data field");

    // A payload result always leaves the newer payload byte held in its place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid && (res.kind == ifr_pkg::KIND_PAYLOAD)) |=> held_valid_reg)
        else $error("payload emitted without a held byte");

endmodule

`default_nettype wire

### hw/rtl/ifr_out_reg.sv
// Output result register of the information frame receiver.
`default_nettype none

module ifr_out_reg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire ifr_pkg::result_t res,
    output logic             advance,
    output logic             out_valid,
    input  wire logic        out_ready,
    output ifr_pkg::result_t out_res
);

    logic             out_valid_reg;
    logic             out_valid_next;
    ifr_pkg::result_t out_res_reg;

    // The register may be refilled in the same cycle its transaction completes.
    assign advance = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire

### hw/rtl/info_frame_receiver_destuffer_unit.sv
// A result passes through the input register, then is decoded into the output
// register once that register is free. Throughput: one byte per cycle while the output
// register is free or being read; the decode step is a single pass of compare logic.
// A byte that ends no payload, frame, duplicate or disconnect produces no result.
// Reset (rst_n low, asynchronous) returns to flag hunting, clears the sequence,
// the held byte and the counters, and loads the configuration defaults.
`default_nettype none

module info_frame_receiver_destuffer_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ifr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2:0]                         kind,
    output logic [7:0]                         data_byte,
    output logic [1:0]                         reply_kind,
    output logic                               reply_seq,
    output logic [7:0]                         reply_address,
    output logic [ifr_pkg::FRAME_LEN_W-1:0]    frame_length
);

    ifr_pkg::cfg_t    cfg;
    ifr_pkg::result_t res;
    ifr_pkg::result_t out_res;
    logic             advance;
    logic             step;
    logic             res_valid;

    ifr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ifr_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .advance   (advance),
        .step      (step),
        .res_valid (res_valid),
        .res       (res)
    );

    ifr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind          = out_res.kind;
    assign data_byte     = out_res.data_byte;
    assign reply_kind    = out_res.reply_kind;
    assign reply_seq     = out_res.reply_seq;
    assign reply_address = out_res.reply_address;
    assign frame_length  = out_res.frame_length;

endmodule

`default_nettype wire

### tb/sv/info_frame_receiver_destuffer_unit_tb.sv
// Self-checking testbench of the information frame receiver and destuffer.
`timescale 1ns / 100ps

module info_frame_receiver_destuffer_unit_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS = 220;
    localparam int CLEAN_FRAME_BYTES = 40;
    localparam longint unsigned FRAME_MAX = (64'd1 << ifr_pkg::FRAME_LEN_W) - 1;

    typedef enum logic [2:0] {
        RX_HUNT,
        RX_OPEN_FLAG,
        RX_ADDRESS,
        RX_CONTROL,
        RX_PAYLOAD,
        RX_ESCAPED
    } rx_phase_t;

    typedef struct {
        logic [7:0]       rx;
        bit               typed;
        ifr_pkg::result_t res;
    } dir_row_t;

    localparam ifr_pkg::result_t NO_RES = '0;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_wr_en;
    logic [ifr_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [7:0]                          cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic [7:0]                          rx_byte;
    logic                                out_valid;
    logic                                out_ready;
    logic [2:0]                          kind;
    logic [7:0]                          data_byte;
    logic [1:0]                          reply_kind;
    logic                                reply_seq;
    logic [7:0]                          reply_address;
    logic [ifr_pkg::FRAME_LEN_W-1:0]     frame_length;

    // Receiver state as the block should hold it.
    ifr_pkg::cfg_t                       link_cfg;
    rx_phase_t                           rx_phase;
    logic                                seq_expected;
    logic [7:0]                          ctrl_held;
    logic [7:0]                          byte_held;
    logic                                byte_held_valid;
    logic [7:0]                          data_xor;
    logic [ifr_pkg::LEN_WIDTH-1:0]       payload_count;

    ifr_pkg::result_t                    report_q[$];
    int                                  mismatches;
    int                                  sent_count;
    int                                  cycle_count;
    bit                                  idle_on;

    // Opening sequence under the reset configuration. Rows with typed results are
    // the ones whose outcome is plain from the frame itself.
    dir_row_t dir_rows [31] = '{
        '{8'h7E, 1'b0, NO_RES},
        '{8'h7E, 1'b0, NO_RES},
        '{8'h03, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h03, 1'b0, NO_RES},
        '{8'h7E, 1'b1, '{ifr_pkg::KIND_REJECT, 8'h00, ifr_pkg::REPLY_REJ, 1'b0, 8'h01,
                         16'd0}},
        '{8'h7E, 1'b0, NO_RES},
        '{8'h03, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        '{8'h03, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'h7D, 1'b0, NO_RES},
        '{8'h5E, 1'b1, '{ifr_pkg::KIND_PAYLOAD, 8'hFF, ifr_pkg::REPLY_NONE, 1'b0, 8'h00,
                         16'd0}},
        '{8'h00, 1'b1, '{ifr_pkg::KIND_PAYLOAD, 8'h7E, ifr_pkg::REPLY_NONE, 1'b0, 8'h00,
                         16'd0}},
        '{8'h81, 1'b1, '{ifr_pkg::KIND_PAYLOAD, 8'h00, ifr_pkg::REPLY_NONE, 1'b0, 8'h00,
                         16'd0}},
        '{8'h7E, 1'b1, '{ifr_pkg::KIND_ACCEPT, 8'h00, ifr_pkg::REPLY_RR, 1'b0, 8'h01,
                         16'd3}},
        '{8'h7E, 1'b0, NO_RES},
        '{8'h03, 1'b0, NO_RES},
        '{8'h00, 1'b1, '{ifr_pkg::KIND_DUPLICATE, 8'h00, ifr_pkg::REPLY_RR, 1'b0, 8'h03,
                         16'd0}},
        '{8'h7E, 1'b0, NO_RES},
        '{8'h03, 1'b0, NO_RES},
        '{8'h0B, 1'b1, '{ifr_pkg::KIND_DISC, 8'h00, ifr_pkg::REPLY_DISC, 1'b0, 8'h03,
                         16'd0}},
        '{8'h7E, 1'b0, NO_RES},
        '{8'h03, 1'b0, NO_RES},
        '{8'h7E, 1'b0, NO_RES},
        '{8'h03, 1'b0, NO_RES},
        '{8'h40, 1'b0, NO_RES},
        '{8'h43, 1'b0, NO_RES},
        '{8'h12, 1'b0, NO_RES},
        '{8'h34, 1'b0, NO_RES},
        '{8'h7E, 1'b0, NO_RES}
    };

    info_frame_receiver_destuffer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .data_byte     (data_byte),
        .reply_kind    (reply_kind),
        .reply_seq     (reply_seq),
        .reply_address (reply_address),
        .frame_length  (frame_length)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advances the receiver by one byte; returns 1 when the byte yields a result.
    function automatic bit destuff_decode(input logic [7:0] b, output ifr_pkg::result_t r);
        logic [7:0]                      want_ctrl;
        logic [7:0]                      dup_ctrl;
        logic [7:0]                      dbyte;
        logic [ifr_pkg::FRAME_LEN_W-1:0] len_rep;
        longint unsigned                 len_now;
        bit                              is_data;
        bit                              made;
        want_ctrl = seq_expected ? link_cfg.info_ctrl_seq1 : link_cfg.info_ctrl_seq0;
        dup_ctrl = seq_expected ? link_cfg.info_ctrl_seq0 : link_cfg.info_ctrl_seq1;
        len_now = payload_count;
        len_rep = (len_now > FRAME_MAX) ? {ifr_pkg::FRAME_LEN_W{1'b1}}
                                        : ifr_pkg::FRAME_LEN_W'(len_now);
        r = '0;
        dbyte = b;
        is_data = 1'b0;
        made = 1'b0;
        case (rx_phase)
            RX_HUNT:
            begin
                if (b == link_cfg.flag_byte)
                    rx_phase = RX_OPEN_FLAG;
            end
            RX_OPEN_FLAG:
            begin
                if (b == link_cfg.sender_address)
                    rx_phase = RX_ADDRESS;
                else if (b != link_cfg.flag_byte)
                    rx_phase = RX_HUNT;
            end
            RX_ADDRESS:
            begin
                if (b == want_ctrl)
                begin
                    ctrl_held = b;
                    rx_phase = RX_CONTROL;
                end
                else if (b == dup_ctrl)
                begin
                    rx_phase = RX_HUNT;
                    r.kind = ifr_pkg::KIND_DUPLICATE;
                    r.reply_kind = ifr_pkg::REPLY_RR;
                    r.reply_seq = ~seq_expected;
                    r.reply_address = link_cfg.sender_address;
                    made = 1'b1;
                end
                else if (b == link_cfg.disc_ctrl)
                begin
                    rx_phase = RX_HUNT;
                    r.kind = ifr_pkg::KIND_DISC;
                    r.reply_kind = ifr_pkg::REPLY_DISC;
                    r.reply_address = link_cfg.sender_address;
                    made = 1'b1;
                end
                else if (b == link_cfg.flag_byte)
                    rx_phase = RX_OPEN_FLAG;
                else
                    rx_phase = RX_HUNT;
            end
            RX_CONTROL:
            begin
                if (b == (ctrl_held ^ link_cfg.sender_address))
                begin
                    rx_phase = RX_PAYLOAD;
                    byte_held_valid = 1'b0;
                    byte_held = 8'h00;
                    data_xor = 8'h00;
                    payload_count = '0;
                end
                else if (b == link_cfg.flag_byte)
                    rx_phase = RX_OPEN_FLAG;
                else
                    rx_phase = RX_HUNT;
            end
            RX_PAYLOAD:
            begin
                if (b == link_cfg.escape_byte)
                    rx_phase = RX_ESCAPED;
                else if (b == link_cfg.flag_byte)
                begin
                    rx_phase = RX_HUNT;
                    r.reply_seq = seq_expected;
                    r.reply_address = link_cfg.receiver_address;
                    if (byte_held_valid && byte_held == data_xor)
                    begin
                        r.kind = ifr_pkg::KIND_ACCEPT;
                        r.reply_kind = ifr_pkg::REPLY_RR;
                        r.frame_length = len_rep;
                        seq_expected = ~seq_expected;
                    end
                    else
                    begin
                        r.kind = ifr_pkg::KIND_REJECT;
                        r.reply_kind = ifr_pkg::REPLY_REJ;
                        r.frame_length = byte_held_valid ? len_rep : '0;
                    end
                    byte_held_valid = 1'b0;
                    made = 1'b1;
                end
                else
                    is_data = 1'b1;
            end
            RX_ESCAPED:
            begin
                rx_phase = RX_PAYLOAD;
                dbyte = b ^ link_cfg.stuff_mask;
                is_data = 1'b1;
            end
            default:
                rx_phase = RX_HUNT;
        endcase
        // The previous payload byte goes out only once a newer one arrives.
        if (is_data)
        begin
            if (byte_held_valid)
            begin
                r.kind = ifr_pkg::KIND_PAYLOAD;
                r.data_byte = byte_held;
                data_xor = data_xor ^ byte_held;
                if (payload_count != {ifr_pkg::LEN_WIDTH{1'b1}})
                    payload_count = payload_count + 1'b1;
                made = 1'b1;
            end
            byte_held = dbyte;
            byte_held_valid = 1'b1;
        end
        return made;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input ifr_pkg::result_t typed_res = '0);
        int               gap;
        ifr_pkg::result_t r;
        bit               made;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sent_count++;
        made = destuff_decode(b, r);
        if (typed)
            report_q.push_back(typed_res);
        else if (made)
            report_q.push_back(r);
    endtask

    // Stuffs a payload byte when it collides with a flag or an escape, or when forced.
    task automatic send_stuffed(input logic [7:0] d, input bit forced);
        if (forced || d == link_cfg.flag_byte || d == link_cfg.escape_byte)
        begin
            send_byte(link_cfg.escape_byte);
            send_byte(d ^ link_cfg.stuff_mask);
        end
        else
            send_byte(d);
    endtask

    task automatic send_frame(input int len, input bit clean);
        logic [7:0] ctrl;
        logic [7:0] chk;
        logic [7:0] d;
        int         pick;
        int         i;
        send_byte(link_cfg.flag_byte);
        if (!clean && $urandom_range(0, 3) == 0)
            send_byte(link_cfg.flag_byte);
        send_byte((clean || $urandom_range(0, 9) != 0) ? link_cfg.sender_address
                                                       : 8'($urandom));
        pick = clean ? 0 : $urandom_range(0, 9);
        if (pick < 7)
            ctrl = seq_expected ? link_cfg.info_ctrl_seq1 : link_cfg.info_ctrl_seq0;
        else if (pick == 7)
            ctrl = seq_expected ? link_cfg.info_ctrl_seq0 : link_cfg.info_ctrl_seq1;
        else if (pick == 8)
            ctrl = link_cfg.disc_ctrl;
        else
            ctrl = 8'($urandom);
        send_byte(ctrl);
        send_byte((clean || $urandom_range(0, 9) != 0) ? ctrl ^ link_cfg.sender_address
                                                       : 8'($urandom));
        chk = 8'h00;
        for (i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 11);
            case (pick)
                0: d = link_cfg.flag_byte;
                1: d = link_cfg.escape_byte;
                2: d = link_cfg.flag_byte ^ link_cfg.stuff_mask;
                default: d = 8'($urandom);
            endcase
            // An escape followed by a raw flag must be taken as data.
            send_stuffed(d, pick == 2);
            chk = chk ^ d;
        end
        if (!clean && $urandom_range(0, 9) == 0)
            chk = 8'($urandom);
        if (clean || len != 0 || $urandom_range(0, 3) != 0)
            send_stuffed(chk, 1'b0);
        send_byte(link_cfg.flag_byte);
    endtask

    task automatic random_phase(input int n);
        int start;
        int k;
        start = sent_count;
        while (sent_count - start < n)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
            begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                    send_byte(8'($urandom));
            end
            send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                    : $urandom_range(0, 12), 1'b0);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [ifr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            ifr_pkg::CFG_FLAG_BYTE:        link_cfg.flag_byte = val;
            ifr_pkg::CFG_ESCAPE_BYTE:      link_cfg.escape_byte = val;
            ifr_pkg::CFG_STUFF_MASK:       link_cfg.stuff_mask = val;
            ifr_pkg::CFG_SENDER_ADDRESS:   link_cfg.sender_address = val;
            ifr_pkg::CFG_RECEIVER_ADDRESS: link_cfg.receiver_address = val;
            ifr_pkg::CFG_INFO_CTRL_SEQ0:   link_cfg.info_ctrl_seq0 = val;
            ifr_pkg::CFG_INFO_CTRL_SEQ1:   link_cfg.info_ctrl_seq1 = val;
            ifr_pkg::CFG_DISC_CTRL:        link_cfg.disc_ctrl = val;
            default: ;
        endcase
    endtask

    task automatic load_config(input ifr_pkg::cfg_t c);
        set_reg(ifr_pkg::CFG_FLAG_BYTE, c.flag_byte);
        set_reg(ifr_pkg::CFG_ESCAPE_BYTE, c.escape_byte);
        set_reg(ifr_pkg::CFG_STUFF_MASK, c.stuff_mask);
        set_reg(ifr_pkg::CFG_SENDER_ADDRESS, c.sender_address);
        set_reg(ifr_pkg::CFG_RECEIVER_ADDRESS, c.receiver_address);
        set_reg(ifr_pkg::CFG_INFO_CTRL_SEQ0, c.info_ctrl_seq0);
        set_reg(ifr_pkg::CFG_INFO_CTRL_SEQ1, c.info_ctrl_seq1);
        set_reg(ifr_pkg::CFG_DISC_CTRL, c.disc_ctrl);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string fname, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
        end
    endtask

    initial
    begin
        ifr_pkg::cfg_t alt_cfg;
        int            i;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = 8'h00;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        mismatches = 0;
        sent_count = 0;
        idle_on = 1'b1;
        link_cfg = '{8'h7E, 8'h7D, 8'h20, 8'h03, 8'h01, 8'h00, 8'h40, 8'h0B};
        rx_phase = RX_HUNT;
        seq_expected = 1'b0;
        ctrl_held = 8'h00;
        byte_held = 8'h00;
        byte_held_valid = 1'b0;
        data_xor = 8'h00;
        payload_count = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(dir_rows); i++)
            send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);

        // One clean frame with no idle cycles on either side.
        idle_on = 1'b0;
        send_frame(CLEAN_FRAME_BYTES, 1'b1);
        random_phase(PHASE_ITEMS);

        wait_idle();
        alt_cfg = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80};
        load_config(alt_cfg);
        random_phase(PHASE_ITEMS);

        // Flag, disconnect and sequence-1 controls share one value here.
        wait_idle();
        alt_cfg = '{8'h00, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};
        load_config(alt_cfg);
        random_phase(PHASE_ITEMS);

        repeat (2)
        begin
            wait_idle();
            alt_cfg.flag_byte = 8'($urandom);
            alt_cfg.escape_byte = alt_cfg.flag_byte ^ 8'($urandom_range(1, 255));
            alt_cfg.stuff_mask = 8'($urandom);
            alt_cfg.sender_address = 8'($urandom);
            alt_cfg.receiver_address = 8'($urandom);
            alt_cfg.info_ctrl_seq0 = 8'($urandom);
            alt_cfg.info_ctrl_seq1 = 8'($urandom);
            alt_cfg.disc_ctrl = 8'($urandom);
            load_config(alt_cfg);
            random_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (mismatches == 0)
            $display("info_frame_receiver_destuffer_unit: match");
        else
            $display("info_frame_receiver_destuffer_unit: mismatch");
        $finish;
    end

    // Result side: random stall before each transaction, none while idling is off.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        ifr_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (report_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result expected none actual kind %0h data %0h",
                         $time, kind, data_byte);
            end
            else
            begin
                want = report_q.pop_front();
                check_field("kind", want.kind, kind);
                check_field("data_byte", want.data_byte, data_byte);
                check_field("reply_kind", want.reply_kind, reply_kind);
                check_field("reply_seq", want.reply_seq, reply_seq);
                check_field("reply_address", want.reply_address, reply_address);
                check_field("frame_length", want.frame_length, frame_length);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("info_frame_receiver_destuffer_unit: mismatch");
                $finish;
            end
        end
    end

endmodule

### files.f
hw/rtl/ifr_pkg.sv
hw/rtl/ifr_cfg_regs.sv
hw/rtl/ifr_decoder.sv
hw/rtl/ifr_out_reg.sv
hw/rtl/info_frame_receiver_destuffer_unit.sv
tb/sv/info_frame_receiver_destuffer_unit_tb.sv
